### rtl/rbt_pkg.sv
// Package for the reorder buffer table: operation and status codes,
// opcode constants and the stored entry layout. No dependencies.
package rbt_pkg;

  typedef enum logic [2:0] {
    OP_INSERT     = 3'd0,
    OP_READ       = 3'd1,
    OP_UPDATE     = 3'd2,
    OP_COMMIT     = 3'd3,
    OP_FLUSH_ALL  = 3'd4,
    OP_FLUSH_FROM = 3'd5,
    OP_RM_BRANCH  = 3'd6,
    OP_RM_STORE   = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_REG      = 3'd2,
    ST_ABSENT   = 3'd3,
    ST_NOCOMMIT = 3'd4,
    ST_KIND     = 3'd5
  } status_e;

  localparam logic [5:0] OPC_STORE  = 6'd10;
  localparam logic [5:0] OPC_BRANCH = 6'd11;

  localparam int unsigned CFG_CAPACITY  = 0;
  localparam int unsigned CFG_REG_LIMIT = 1;

  typedef struct packed {
    logic [31:0]        tag;
    logic [7:0]         dest;
    logic [5:0]         opcode;
    logic signed [31:0] result;
    logic               done;
  } entry_t;

endpackage

### rtl/rob_in_if.sv
// Request channel of the reorder buffer table: valid/ready plus one operation.
// Depends on nothing.
interface rob_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic [31:0]        instr_tag;
  logic [7:0]         dest_reg;
  logic [5:0]         instr_opcode;
  logic signed [31:0] result_value;

  modport source (output valid, operation, instr_tag, dest_reg, instr_opcode, result_value,
                  input ready);
  modport sink   (input valid, operation, instr_tag, dest_reg, instr_opcode, result_value,
                  output ready);
endinterface

### rtl/rob_out_if.sv
// Response channel of the reorder buffer table: valid/ready plus one result.
// Depends on nothing.
interface rob_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [31:0]        out_tag;
  logic [7:0]         out_dest_reg;
  logic [5:0]         out_opcode;
  logic signed [31:0] out_result;
  logic               out_done;
  logic               buffer_full;
  logic               buffer_empty;

  modport source (output valid, status, out_tag, out_dest_reg, out_opcode, out_result,
                  out_done, buffer_full, buffer_empty, input ready);
  modport sink   (input valid, status, out_tag, out_dest_reg, out_opcode, out_result,
                  out_done, buffer_full, buffer_empty, output ready);
endinterface

### rtl/rbt_store.sv
// Entry memory of the reorder buffer table: one write port, one read port,
// read data registered. Uses rbt_pkg::entry_t.
module rbt_store #(
  parameter int unsigned ENTRIES = 32,
  parameter int unsigned IW      = 5
) (
  input  logic           clk_i,
  input  logic           rd_en_i,
  input  logic [IW-1:0]  rd_addr_i,
  output rbt_pkg::entry_t rd_data_o,
  input  logic           wr_en_i,
  input  logic [IW-1:0]  wr_addr_i,
  input  rbt_pkg::entry_t wr_data_i
);

  rbt_pkg::entry_t mem [ENTRIES];
  rbt_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/reorder_buffer_table.sv
// Reorder buffer table: tagged entries (tag, destination, opcode, result,
// done) kept in a synchronous memory, with valid bits and a count in flops.
//
// Usage: one operation is taken per beat on in_i (valid/ready) and exactly
// one result beat is returned on out_o. Configuration (capacity, register
// limit) is written through cfg_we_i/cfg_idx_i/cfg_wdata_i while idle.
// Every operation except flush all walks the whole entry memory, one entry
// per cycle, to find the tag, the first free slot and the oldest entry; a
// finish state applies the change and loads the output register. The entry
// memory has a single read port. in_i.ready is high only while no operation
// is in progress. A result waiting in the output register does not block
// acceptance; the finish state of the next operation waits until the
// receiver has taken it. Reset empties the buffer and restores capacity 32
// and register limit 255; memory contents are not cleared.
module reorder_buffer_table #(
  parameter int unsigned ENTRIES = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rob_in_if.sink     in_i,
  rob_out_if.source  out_o,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_e;

  state_e           state_q;
  rbt_pkg::op_e     op_q;
  logic [31:0]      key_q;
  logic [7:0]       dest_q;
  logic [5:0]       opc_q;
  logic signed [31:0] val_q;

  logic [5:0]       capacity_q;
  logic [7:0]       limit_q;

  logic [ENTRIES-1:0] valid_q;
  logic [CW-1:0]    count_q;
  logic [CW-1:0]    cnt_q;
  logic             rd_vld_q;
  logic [IW-1:0]    rd_idx_q;

  logic             found_q, free_found_q, old_found_q;
  logic [IW-1:0]    f_idx_q, free_idx_q, old_idx_q;
  rbt_pkg::entry_t  f_ent_q, old_ent_q;

  rbt_pkg::entry_t  rd_ent;
  logic             rd_en;

  // Finish-cycle results.
  logic [ENTRIES-1:0] valid_f;
  logic [CW-1:0]    count_f;
  rbt_pkg::status_e st_f;
  rbt_pkg::entry_t  o_ent;
  logic             o_done;
  logic             wr_en;
  logic [IW-1:0]    wr_idx;
  rbt_pkg::entry_t  wr_ent;
  logic             full_now, fin_go;
  logic [5:0]       kind_opc;

  assign rd_en = (state_q == S_SCAN) && (cnt_q < CW'(ENTRIES));
  assign fin_go = (state_q == S_FINISH) && (!out_o.valid || out_o.ready);
  assign in_i.ready = (state_q == S_IDLE);

  rbt_store #(.ENTRIES(ENTRIES), .IW(IW)) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (cnt_q[IW-1:0]),
    .rd_data_o (rd_ent),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_idx),
    .wr_data_i (wr_ent)
  );

  always_comb begin
    valid_f  = valid_q;
    count_f  = count_q;
    st_f     = rbt_pkg::ST_OK;
    o_ent    = '0;
    o_done   = 1'b0;
    wr_en    = 1'b0;
    wr_idx   = free_idx_q;
    wr_ent   = '{tag: key_q, dest: dest_q, opcode: opc_q, result: '0, done: 1'b0};
    full_now = (9'(count_q) >= 9'(capacity_q)) || (9'(count_q) >= 9'(ENTRIES));
    kind_opc = (op_q == rbt_pkg::OP_RM_BRANCH) ? rbt_pkg::OPC_BRANCH : rbt_pkg::OPC_STORE;
    case (op_q)
      rbt_pkg::OP_INSERT: begin
        if (full_now) begin
          st_f = rbt_pkg::ST_FULL;
        end else if (dest_q > limit_q) begin
          st_f = rbt_pkg::ST_REG;
        end else if (!found_q) begin
          if (free_found_q) begin
            wr_en               = fin_go;
            valid_f[free_idx_q] = 1'b1;
            count_f             = count_q + 1'b1;
          end else begin
            st_f = rbt_pkg::ST_FULL;
          end
        end
      end
      rbt_pkg::OP_READ: begin
        if (found_q) begin
          o_ent  = f_ent_q;
          o_done = f_ent_q.done;
        end else begin
          st_f = rbt_pkg::ST_ABSENT;
        end
      end
      rbt_pkg::OP_UPDATE: begin
        if (found_q) begin
          wr_en         = fin_go;
          wr_idx        = f_idx_q;
          wr_ent        = f_ent_q;
          wr_ent.result = val_q;
          wr_ent.done   = 1'b1;
        end else begin
          st_f = rbt_pkg::ST_ABSENT;
        end
      end
      rbt_pkg::OP_COMMIT: begin
        if (old_found_q && old_ent_q.done) begin
          o_ent              = old_ent_q;
          o_done             = 1'b1;
          valid_f[old_idx_q] = 1'b0;
          count_f            = count_q - 1'b1;
        end else begin
          st_f = rbt_pkg::ST_NOCOMMIT;
        end
      end
      rbt_pkg::OP_FLUSH_ALL: begin
        valid_f = '0;
        count_f = '0;
      end
      rbt_pkg::OP_FLUSH_FROM: begin
        // Entries were dropped during the scan.
      end
      rbt_pkg::OP_RM_BRANCH, rbt_pkg::OP_RM_STORE: begin
        if (!found_q) begin
          st_f = rbt_pkg::ST_ABSENT;
        end else if (f_ent_q.opcode != kind_opc) begin
          st_f = rbt_pkg::ST_KIND;
        end else begin
          valid_f[f_idx_q] = 1'b0;
          count_f          = count_q - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= 6'd32;
      limit_q    <= 8'd255;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        1'(rbt_pkg::CFG_CAPACITY):  capacity_q <= cfg_wdata_i[5:0];
        1'(rbt_pkg::CFG_REG_LIMIT): limit_q    <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      valid_q      <= '0;
      count_q      <= '0;
      cnt_q        <= '0;
      rd_vld_q     <= 1'b0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      old_found_q  <= 1'b0;
      out_o.valid  <= 1'b0;
    end else begin
      if (out_o.valid && out_o.ready && !fin_go) begin
        out_o.valid <= 1'b0;
      end
      rd_vld_q <= rd_en;
      rd_idx_q <= cnt_q[IW-1:0];
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            op_q         <= rbt_pkg::op_e'(in_i.operation);
            key_q        <= in_i.instr_tag;
            dest_q       <= in_i.dest_reg;
            opc_q        <= in_i.instr_opcode;
            val_q        <= in_i.result_value;
            found_q      <= 1'b0;
            free_found_q <= 1'b0;
            old_found_q  <= 1'b0;
            cnt_q        <= '0;
            state_q      <= (rbt_pkg::op_e'(in_i.operation) == rbt_pkg::OP_FLUSH_ALL)
                            ? S_FINISH : S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            cnt_q <= cnt_q + 1'b1;
          end
          if (rd_vld_q) begin
            if (valid_q[rd_idx_q] && rd_ent.tag == key_q && !found_q) begin
              found_q <= 1'b1;
              f_idx_q <= rd_idx_q;
              f_ent_q <= rd_ent;
            end
            if (!valid_q[rd_idx_q] && !free_found_q) begin
              free_found_q <= 1'b1;
              free_idx_q   <= rd_idx_q;
            end
            if (valid_q[rd_idx_q] && (!old_found_q || rd_ent.tag < old_ent_q.tag)) begin
              old_found_q <= 1'b1;
              old_idx_q   <= rd_idx_q;
              old_ent_q   <= rd_ent;
            end
            if (op_q == rbt_pkg::OP_FLUSH_FROM && valid_q[rd_idx_q] && rd_ent.tag >= key_q) begin
              valid_q[rd_idx_q] <= 1'b0;
              count_q           <= count_q - 1'b1;
            end
          end else if (!rd_en) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (fin_go) begin
            valid_q            <= valid_f;
            count_q            <= count_f;
            out_o.valid        <= 1'b1;
            out_o.status       <= st_f;
            out_o.out_tag      <= o_ent.tag;
            out_o.out_dest_reg <= o_ent.dest;
            out_o.out_opcode   <= o_ent.opcode;
            out_o.out_result   <= o_ent.result;
            out_o.out_done     <= o_done;
            out_o.buffer_full  <= (9'(count_f) >= 9'(capacity_q)) ||
                                  (9'(count_f) >= 9'(ENTRIES));
            out_o.buffer_empty <= (count_f == '0);
            state_q            <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CW'($countones(valid_q)))
    else $error("entry count disagrees with valid bits");

  a_fail_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status != rbt_pkg::ST_OK |-> out_o.out_tag == '0 && !out_o.out_done)
    else $error("failed operation returned entry data");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("new beat taken while an operation is in progress");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> out_o.buffer_empty == (count_q == '0))
    else $error("empty flag disagrees with entry count");
`endif

endmodule

### tb/rob_tb_if.sv
`timescale 1ns / 100ps
// Testbench view of the channels: nothing beyond the RTL interfaces is needed,
// so this file only holds the shared beat records. Depends on rbt_pkg.
package rob_tb_pkg;

  typedef struct {
    rbt_pkg::op_e       op;
    logic [31:0]        tag;
    logic [7:0]         dest;
    logic [5:0]         opcode;
    logic signed [31:0] value;
  } rob_req_t;

  typedef struct {
    rbt_pkg::status_e   status;
    logic [31:0]        tag;
    logic [7:0]         dest;
    logic [5:0]         opcode;
    logic signed [31:0] result;
    logic               done;
    logic               full;
    logic               empty;
  } rob_rsp_t;
endpackage

### tb/reorder_buffer_table_tb.sv
`timescale 1ns / 100ps
// Testbench of reorder_buffer_table: random and directed operations are driven
// through rob_in_if, results on rob_out_if are checked against a table model.
// Depends on rbt_pkg, rob_tb_pkg, rob_in_if, rob_out_if and the RTL.
module reorder_buffer_table_tb;

  localparam int unsigned DEPTH = 32;
  localparam int unsigned WATCHDOG = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_idx_i = '0;
  logic [7:0] cfg_wdata_i = '0;

  rob_in_if  in_ch ();
  rob_out_if out_ch ();

  reorder_buffer_table #(.ENTRIES(DEPTH)) i_dut (
    .clk_i, .rst_ni, .in_i(in_ch), .out_o(out_ch),
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Table model state
  logic        tb_valid [DEPTH];
  logic [31:0] tb_tag [DEPTH];
  logic [7:0]  tb_dest [DEPTH];
  logic [5:0]  tb_opc [DEPTH];
  logic signed [31:0] tb_res [DEPTH];
  logic        tb_done [DEPTH];
  int unsigned tb_count;
  logic [5:0]  cap_reg;
  logic [7:0]  limit_reg;

  rob_tb_pkg::rob_req_t pending_ops[$];
  rob_tb_pkg::rob_rsp_t expected_rsps[$];
  logic [31:0] live_tags[$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct = 0, recv_idle_pct = 0;
  bit hold_off = 1'b0;

  function automatic int unsigned eff_cap();
    return (cap_reg < DEPTH) ? cap_reg : DEPTH;
  endfunction

  function automatic int find_entry(logic [31:0] t);
    for (int i = 0; i < DEPTH; i++)
      if (tb_valid[i] && tb_tag[i] == t) return i;
    return -1;
  endfunction

  function automatic rob_tb_pkg::rob_rsp_t predict_op(rob_tb_pkg::rob_req_t rq);
    rob_tb_pkg::rob_rsp_t r;
    int k;
    r = '{status: rbt_pkg::ST_OK, tag: '0, dest: '0, opcode: '0, result: '0, done: 1'b0,
          full: 1'b0, empty: 1'b0};
    k = -1;
    case (rq.op)
      rbt_pkg::OP_INSERT: begin
        if (tb_count >= eff_cap()) r.status = rbt_pkg::ST_FULL;
        else if (rq.dest > limit_reg) r.status = rbt_pkg::ST_REG;
        else if (find_entry(rq.tag) < 0) begin
          for (int i = 0; i < DEPTH; i++)
            if (!tb_valid[i] && k < 0) k = i;
          if (k < 0) r.status = rbt_pkg::ST_FULL;
          else begin
            tb_valid[k] = 1'b1; tb_tag[k] = rq.tag; tb_dest[k] = rq.dest;
            tb_opc[k] = rq.opcode; tb_res[k] = '0; tb_done[k] = 1'b0;
            tb_count++;
          end
        end
      end
      rbt_pkg::OP_READ, rbt_pkg::OP_UPDATE: begin
        k = find_entry(rq.tag);
        if (k < 0) r.status = rbt_pkg::ST_ABSENT;
        else if (rq.op == rbt_pkg::OP_UPDATE) begin
          tb_res[k] = rq.value; tb_done[k] = 1'b1;
        end else begin
          r.tag = tb_tag[k]; r.dest = tb_dest[k]; r.opcode = tb_opc[k];
          r.result = tb_res[k]; r.done = tb_done[k];
        end
      end
      rbt_pkg::OP_COMMIT: begin
        for (int i = 0; i < DEPTH; i++)
          if (tb_valid[i] && (k < 0 || tb_tag[i] < tb_tag[k])) k = i;
        if (k < 0 || !tb_done[k]) r.status = rbt_pkg::ST_NOCOMMIT;
        else begin
          r.tag = tb_tag[k]; r.dest = tb_dest[k]; r.opcode = tb_opc[k];
          r.result = tb_res[k]; r.done = 1'b1;
          tb_valid[k] = 1'b0; tb_count--;
        end
      end
      rbt_pkg::OP_FLUSH_ALL: begin
        foreach (tb_valid[i]) tb_valid[i] = 1'b0;
        tb_count = 0;
      end
      rbt_pkg::OP_FLUSH_FROM: begin
        for (int i = 0; i < DEPTH; i++)
          if (tb_valid[i] && tb_tag[i] >= rq.tag) begin
            tb_valid[i] = 1'b0; tb_count--;
          end
      end
      default: begin
        k = find_entry(rq.tag);
        if (k < 0) r.status = rbt_pkg::ST_ABSENT;
        else if (tb_opc[k] != ((rq.op == rbt_pkg::OP_RM_BRANCH) ? rbt_pkg::OPC_BRANCH
                                                                  : rbt_pkg::OPC_STORE))
          r.status = rbt_pkg::ST_KIND;
        else begin
          tb_valid[k] = 1'b0; tb_count--;
        end
      end
    endcase
    r.full = (tb_count >= eff_cap());
    r.empty = (tb_count == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Driver: valid stays high across back-to-back beats.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          rob_tb_pkg::rob_req_t rq;
          rq = pending_ops.pop_front();
          expected_rsps.push_back(predict_op(rq));
          in_ch.valid <= 1'b1;
          in_ch.operation <= rq.op;
          in_ch.instr_tag <= rq.tag;
          in_ch.dest_reg <= rq.dest;
          in_ch.instr_opcode <= rq.opcode;
          in_ch.result_value <= rq.value;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor, receiver stall and watchdog.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected beat", out_ch.status, 0);
        end else begin
          rob_tb_pkg::rob_rsp_t e;
          e = expected_rsps.pop_front();
          if (out_ch.status !== e.status) report_mismatch("status", out_ch.status, e.status);
          if (out_ch.out_tag !== e.tag) report_mismatch("out_tag", out_ch.out_tag, e.tag);
          if (out_ch.out_dest_reg !== e.dest)
            report_mismatch("out_dest_reg", out_ch.out_dest_reg, e.dest);
          if (out_ch.out_opcode !== e.opcode)
            report_mismatch("out_opcode", out_ch.out_opcode, e.opcode);
          if (out_ch.out_result !== e.result)
            report_mismatch("out_result", out_ch.out_result, e.result);
          if (out_ch.out_done !== e.done) report_mismatch("out_done", out_ch.out_done, e.done);
          if (out_ch.buffer_full !== e.full)
            report_mismatch("buffer_full", out_ch.buffer_full, e.full);
          if (out_ch.buffer_empty !== e.empty)
            report_mismatch("buffer_empty", out_ch.buffer_empty, e.empty);
        end
      end
      out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_tag();
    if (live_tags.size() > 0 && $urandom_range(99) < 80)
      return live_tags[$urandom_range(live_tags.size() - 1)];
    return $urandom_range(60);
  endfunction

  function automatic rob_tb_pkg::rob_req_t make_op(rbt_pkg::op_e op, logic [31:0] tag,
                                                   logic [7:0] dest, logic [5:0] opc,
                                                   logic [31:0] value);
    rob_tb_pkg::rob_req_t rq;
    rq.op = op; rq.tag = tag; rq.dest = dest; rq.opcode = opc; rq.value = value;
    return rq;
  endfunction

  // Random phase: mostly insert/update/commit flows on a small tag pool.
  task automatic queue_random(int unsigned n);
    rob_tb_pkg::rob_req_t rq;
    int unsigned w;
    for (int unsigned i = 0; i < n; i++) begin
      w = $urandom_range(99);
      if (w < 30) begin
        rq = make_op(rbt_pkg::OP_INSERT,
                     $urandom_range(99) < 5 ? $urandom : $urandom_range(60),
                     $urandom, $urandom_range(99) < 40 ? rbt_pkg::OPC_STORE + $urandom_range(1)
                                                       : $urandom, 0);
        live_tags.push_back(rq.tag);
        if (live_tags.size() > 40) void'(live_tags.pop_front());
      end else if (w < 52) rq = make_op(rbt_pkg::OP_UPDATE, pick_tag(), 0, 0, $urandom);
      else if (w < 72) rq = make_op(rbt_pkg::OP_COMMIT, $urandom, 0, 0, 0);
      else if (w < 82) rq = make_op(rbt_pkg::OP_READ, pick_tag(), 0, 0, 0);
      else if (w < 90) rq = make_op($urandom_range(1) ? rbt_pkg::OP_RM_BRANCH
                                                      : rbt_pkg::OP_RM_STORE,
                                    pick_tag(), 0, 0, 0);
      else if (w < 97) rq = make_op(rbt_pkg::OP_FLUSH_FROM, pick_tag(), 0, 0, 0);
      else rq = make_op(rbt_pkg::OP_FLUSH_ALL, $urandom, $urandom, $urandom, $urandom);
      pending_ops.push_back(rq);
    end
  endtask

  task automatic drain_and_idle();
    while (pending_ops.size() > 0 || expected_rsps.size() > 0 || in_ch.valid)
      @(posedge clk_i);
    repeat (DEPTH + 8) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [0:0] idx, logic [7:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == rbt_pkg::CFG_CAPACITY) cap_reg = val[5:0]; else limit_reg = val;
  endtask

  initial begin
    foreach (tb_valid[i]) tb_valid[i] = 1'b0;
    tb_count = 0; cap_reg = 6'd32; limit_reg = 8'd255;
    in_ch.valid = 1'b0; in_ch.operation = '0; in_ch.instr_tag = '0;
    in_ch.dest_reg = '0; in_ch.instr_opcode = '0; in_ch.result_value = '0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every operation and the absent, kind and no-commit error paths.
    pending_ops.push_back(make_op(rbt_pkg::OP_COMMIT, 0, 0, 0, 0));
    pending_ops.push_back(make_op(rbt_pkg::OP_READ, 32'hFFFF_FFFF, 0, 0, 0));
    pending_ops.push_back(make_op(rbt_pkg::OP_INSERT, 32'hFFFF_FFFF, 8'hFF, 6'h3F, 0));
    pending_ops.push_back(make_op(rbt_pkg::OP_INSERT, 0, 0, rbt_pkg::OPC_BRANCH, 0));
    pending_ops.push_back(make_op(rbt_pkg::OP_INSERT, 5, 8'hAA, rbt_pkg::OPC_STORE, 0));
    pending_ops.push_back(make_op(rbt_pkg::OP_INSERT, 5, 8'h11, 6'h15, 0));
    pending_ops.push_back(make_op(rbt_pkg::OP_READ, 5, 0, 0, 0));
    pending_ops.push_back(make_op(rbt_pkg::OP_COMMIT, 0, 0, 0, 0));
    pending_ops.push_back(make_op(rbt_pkg::OP_UPDATE, 0, 0, 0, 32'h8000_0000));
    pending_ops.push_back(make_op(rbt_pkg::OP_UPDATE, 0, 0, 0, 32'h7FFF_FFFF));
    pending_ops.push_back(make_op(rbt_pkg::OP_UPDATE, 77, 0, 0, 1));
    pending_ops.push_back(make_op(rbt_pkg::OP_RM_STORE, 0, 0, 0, 0));
    pending_ops.push_back(make_op(rbt_pkg::OP_RM_BRANCH, 5, 0, 0, 0));
    pending_ops.push_back(make_op(rbt_pkg::OP_RM_BRANCH, 99, 0, 0, 0));
    pending_ops.push_back(make_op(rbt_pkg::OP_COMMIT, 0, 0, 0, 0));
    pending_ops.push_back(make_op(rbt_pkg::OP_RM_STORE, 5, 0, 0, 0));
    pending_ops.push_back(make_op(rbt_pkg::OP_FLUSH_FROM, 32'h8000_0000, 0, 0, 0));
    pending_ops.push_back(make_op(rbt_pkg::OP_FLUSH_FROM, 0, 0, 0, 0));
    pending_ops.push_back(make_op(rbt_pkg::OP_FLUSH_ALL, 32'hFFFF_FFFF, 8'hFF, 6'h3F, -1));
    drain_and_idle();

    write_cfg(rbt_pkg::CFG_CAPACITY, 8'd1);
    write_cfg(rbt_pkg::CFG_REG_LIMIT, 8'd0);
    pending_ops.push_back(make_op(rbt_pkg::OP_INSERT, 3, 8'd1, 0, 0));
    pending_ops.push_back(make_op(rbt_pkg::OP_INSERT, 3, 8'd0, 0, 0));
    pending_ops.push_back(make_op(rbt_pkg::OP_INSERT, 4, 8'd0, 0, 0));
    queue_random(60);
    drain_and_idle();
    write_cfg(rbt_pkg::CFG_CAPACITY, 8'd0);
    queue_random(20);
    drain_and_idle();
    write_cfg(rbt_pkg::CFG_CAPACITY, 8'd63);
    write_cfg(rbt_pkg::CFG_REG_LIMIT, 8'd128);

    // Long receiver hold-off while the sender keeps offering.
    queue_random(40);
    hold_off = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off = 1'b0;
    drain_and_idle();

    send_idle_pct = 24; recv_idle_pct = 75;
    queue_random(550);
    drain_and_idle();
    write_cfg(rbt_pkg::CFG_CAPACITY, 8'd8);
    write_cfg(rbt_pkg::CFG_REG_LIMIT, 8'd255);
    send_idle_pct = 75; recv_idle_pct = 24;
    queue_random(550);
    drain_and_idle();
    write_cfg(rbt_pkg::CFG_CAPACITY, 8'd32);
    send_idle_pct = 0; recv_idle_pct = 0;
    queue_random(650);
    drain_and_idle();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
